// ===== src/budget_greedy_sort_select_macros.svh =====
// Assertion macros shared by the budget greedy select RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef BUDGET_GREEDY_SORT_SELECT_MACROS_SVH
`define BUDGET_GREEDY_SORT_SELECT_MACROS_SVH
`ifndef SYNTHESIS
`define BGSS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgss assertion failed");
`define BGSS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgss assertion failed");
`else
`define BGSS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BGSS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/bgss_pkg.sv =====
// Types, constants and width helpers for the budget greedy select block.
// No dependencies; used by bgss_cell and budget_greedy_sort_select.
package bgss_pkg;

   localparam int MAX_ITEMS    = 8;
   localparam int COST_BITS    = 16;
   localparam int RESULT_LIMIT = 8;
   localparam int BUDGET_BITS  = 20;
   localparam int FIELD_BITS   = 16;
   localparam int IDX_BITS     = 3;
   localparam int CNT_BITS     = 4;
   localparam int FILL_BITS    = $clog2(MAX_ITEMS + 1);
   localparam int SUM_BITS     = ((BUDGET_BITS > COST_BITS) ? BUDGET_BITS : COST_BITS) + 1;

   localparam logic [BUDGET_BITS-1:0] BUDGET_INIT = BUDGET_BITS'(100);
   localparam logic [FILL_BITS-1:0]   FILL_ONE    = FILL_BITS'(1);
   localparam logic [CNT_BITS-1:0]    CNT_ONE     = CNT_BITS'(1);

   typedef struct packed {
      logic [FIELD_BITS-1:0] item_cost;
      logic [FIELD_BITS-1:0] item_volume;
      logic                  item_last;
   } req_item_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]    chosen_index;
      logic [FIELD_BITS-1:0]  chosen_volume;
      logic [FIELD_BITS-1:0]  chosen_cost;
      logic [CNT_BITS-1:0]    chosen_count;
      logic [BUDGET_BITS-1:0] total_spent;
      logic                   none_chosen;
      logic                   overflow;
      logic                   result_last;
   } rsp_item_type;

   // One stored item as held by a cell of the sort chain
   typedef struct packed {
      logic [COST_BITS-1:0]  cost;
      logic [FIELD_BITS-1:0] volume;
      logic [IDX_BITS-1:0]   index;
   } entry_type;

   typedef struct packed {
      logic insert;   // place the new item, shifting larger ones up
      logic rotate;   // every cell takes its upper neighbor, top takes cell 0
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   function automatic logic [COST_BITS-1:0] to_cost(input logic [FIELD_BITS-1:0] v);
      return COST_BITS'(v);
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input logic [COST_BITS-1:0] v);
      return FIELD_BITS'(v);
   endfunction

   function automatic logic [IDX_BITS-1:0] to_index(input logic [FILL_BITS-1:0] v);
      return IDX_BITS'(v);
   endfunction

   function automatic logic [SUM_BITS-1:0] add_sum(input logic [BUDGET_BITS-1:0] total,
                                                   input logic [COST_BITS-1:0] cost);
      return SUM_BITS'(total) + SUM_BITS'(cost);
   endfunction

   function automatic logic fits(input logic [SUM_BITS-1:0] sum,
                                 input logic [BUDGET_BITS-1:0] budget);
      return sum <= SUM_BITS'(budget);
   endfunction

endpackage

// ===== src/bgss_cell.sv =====
// One cell of the insertion sort chain: holds one item, compares it to the
// arriving item and shifts or rotates with its neighbors. Uses bgss_pkg.
module bgss_cell (
   input  logic                   clock,
   input  bgss_pkg::cell_ctl_type ctl,
   input  logic                   occupied,
   input  bgss_pkg::entry_type    new_entry,
   input  bgss_pkg::entry_type    prev_entry,
   input  logic                   prev_gt,
   input  bgss_pkg::entry_type    next_entry,
   output bgss_pkg::entry_type    entry,
   output logic                   gt
);

   bgss_pkg::entry_type entry_ff;
   bgss_pkg::entry_type entry_in;

   // an empty cell counts as larger, so the item lands at the first free slot
   assign gt = !occupied || (entry_ff.cost > new_entry.cost);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.rotate) begin
         entry_in = next_entry;
      end else if (ctl.insert && gt) begin
         entry_in = prev_gt ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/budget_greedy_sort_select.sv =====
// An accepted item is written into its sorted place in the cell chain; one item per cycle while loading.
// After the last item, a scan rotates the chain once through all MAX_ITEMS cells to sum costs,
// then one result per cycle leaves the output register while rsp_ready back-pressure does not hold it.
// The next set is taken once the final result of the run is in the output register.
// Reset (synchronous, active high) clears fill count, overflow flag and control; budget = 100.
// Depends on bgss_pkg, bgss_cell and the assertion macro header.
`include "budget_greedy_sort_select_macros.svh"

module budget_greedy_sort_select (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bgss_pkg::req_item_type              req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bgss_pkg::rsp_item_type              rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bgss_pkg::BUDGET_BITS-1:0]    csr_data
);

   bgss_pkg::state_type                  state_ff, state_in;
   logic [bgss_pkg::FILL_BITS-1:0]       fill_ff, fill_in;
   logic                                 ovf_ff, ovf_in;
   logic [bgss_pkg::BUDGET_BITS-1:0]     budget_ff;
   logic [bgss_pkg::FILL_BITS-1:0]       step_ff, step_in;
   logic                                 going_ff, going_in;
   logic [bgss_pkg::BUDGET_BITS-1:0]     total_ff, total_in;
   logic [bgss_pkg::CNT_BITS-1:0]        count_ff, count_in;
   logic [bgss_pkg::CNT_BITS-1:0]        emit_ff, emit_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   bgss_pkg::rsp_item_type               rsp_ff, rsp_in;

   bgss_pkg::cell_ctl_type               ctl;
   bgss_pkg::entry_type                  new_entry;
   bgss_pkg::entry_type                  cells [bgss_pkg::MAX_ITEMS];
   logic [bgss_pkg::MAX_ITEMS-1:0]       gt;

   logic                                 req_go;
   logic                                 full;
   logic                                 out_free;
   logic                                 emit_last;
   logic                                 take;
   logic [bgss_pkg::SUM_BITS-1:0]        sum;

   assign req_ready = (state_ff == bgss_pkg::ST_IDLE);
   assign req_go    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign full      = (int'(fill_ff) >= bgss_pkg::MAX_ITEMS);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = (count_ff == '0) || ((int'(emit_ff) + 1) == int'(count_ff));

   assign new_entry.cost   = bgss_pkg::to_cost(req_item.item_cost);
   assign new_entry.volume = req_item.item_volume;
   assign new_entry.index  = bgss_pkg::to_index(fill_ff);

   // cell 0 always shows the item under test during scan and emit
   assign sum  = bgss_pkg::add_sum(total_ff, cells[0].cost);
   assign take = going_ff && (step_ff < fill_ff) &&
                 (int'(count_ff) < bgss_pkg::RESULT_LIMIT) &&
                 bgss_pkg::fits(sum, budget_ff);

   always_comb begin
      ctl.insert = req_go && !full;
      ctl.rotate = (state_ff == bgss_pkg::ST_SCAN) ||
                   ((state_ff == bgss_pkg::ST_EMIT) && out_free);
   end

   for (genvar k = 0; k < bgss_pkg::MAX_ITEMS; k++) begin : g_cell
      bgss_pkg::entry_type prev_entry;
      logic                prev_gt;
      if (k == 0) begin : g_head
         assign prev_entry = new_entry;
         assign prev_gt    = 1'b0;
      end else begin : g_body
         assign prev_entry = cells[k-1];
         assign prev_gt    = gt[k-1];
      end
      bgss_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (k < int'(fill_ff)),
         .new_entry  (new_entry),
         .prev_entry (prev_entry),
         .prev_gt    (prev_gt),
         .next_entry (cells[(k + 1) % bgss_pkg::MAX_ITEMS]),
         .entry      (cells[k]),
         .gt         (gt[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      going_in     = going_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         bgss_pkg::ST_IDLE: begin
            if (req_go) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  fill_in = fill_ff + bgss_pkg::FILL_ONE;
               end
               if (req_item.item_last) begin
                  state_in = bgss_pkg::ST_SCAN;
                  step_in  = '0;
                  going_in = 1'b1;
                  total_in = '0;
                  count_in = '0;
               end
            end
         end
         bgss_pkg::ST_SCAN: begin
            going_in = take;
            if (take) begin
               total_in = bgss_pkg::BUDGET_BITS'(sum);
               count_in = count_ff + bgss_pkg::CNT_ONE;
            end
            step_in = step_ff + bgss_pkg::FILL_ONE;
            // a full turn of the chain leaves the sorted order in place again
            if (int'(step_ff) == bgss_pkg::MAX_ITEMS - 1) begin
               state_in = bgss_pkg::ST_EMIT;
               emit_in  = '0;
            end
         end
         bgss_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.overflow      = ovf_ff;
               rsp_in.result_last   = emit_last;
               rsp_in.chosen_count  = count_ff;
               rsp_in.total_spent   = total_ff;
               if (count_ff == '0) begin
                  rsp_in.chosen_index  = '0;
                  rsp_in.chosen_volume = '0;
                  rsp_in.chosen_cost   = '0;
                  rsp_in.none_chosen   = 1'b1;
               end else begin
                  rsp_in.chosen_index  = cells[0].index;
                  rsp_in.chosen_volume = cells[0].volume;
                  rsp_in.chosen_cost   = bgss_pkg::to_field(cells[0].cost);
                  rsp_in.none_chosen   = 1'b0;
               end
               emit_in = emit_ff + bgss_pkg::CNT_ONE;
               if (emit_last) begin
                  state_in = bgss_pkg::ST_IDLE;
                  fill_in  = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = bgss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bgss_pkg::ST_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         budget_ff    <= bgss_pkg::BUDGET_INIT;
         rsp_valid_ff <= 1'b0;
         going_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         going_ff     <= going_in;
         if (csr_valid && csr_ready) begin
            budget_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      total_ff <= total_in;
      count_ff <= count_in;
      emit_ff  <= emit_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `BGSS_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, int'(fill_ff) <= bgss_pkg::MAX_ITEMS)
   `BGSS_ASSERT_IMP(a_total_in_budget, clock, reset, state_ff == bgss_pkg::ST_EMIT, total_ff <= budget_ff)
   `BGSS_ASSERT_IMP(a_count_bound, clock, reset, state_ff == bgss_pkg::ST_EMIT, int'(count_ff) <= bgss_pkg::RESULT_LIMIT)
   `BGSS_ASSERT_NXT(a_run_clears, clock, reset, state_ff == bgss_pkg::ST_EMIT && out_free && emit_last, fill_ff == '0 && !ovf_ff && rsp_valid_ff && rsp_ff.result_last)

endmodule
